/* hdl/fq_pkg.sv */
// Shared types, codes and constants of the symmetric fake quantizer.
`timescale 1ns / 1ps

package fq_pkg;

    // Default width of a sample, of the running maximum and of a dequantized value.
    localparam int SAMPLE_WIDTH_DEF = 32;

    // Width of a quantized value, which is also the number of quotient bits
    // that the first division has to find.
    localparam int QBITS = 8;

    // Item kinds.
    localparam logic [1:0] KIND_CLEAR    = 2'd0;
    localparam logic [1:0] KIND_CALIB    = 2'd1;
    localparam logic [1:0] KIND_QUANTIZE = 2'd2;

    // Quantization modes.
    localparam logic [1:0] MODE_INT8 = 2'd0;
    localparam logic [1:0] MODE_INT4 = 2'd1;

    localparam logic [QBITS-1:0] QMAX_INT8 = 8'd127;
    localparam logic [QBITS-1:0] QMAX_INT4 = 8'd7;
    localparam logic [QBITS-1:0] QMAX_INT2 = 8'd1;

    // Largest magnitude of a quantized value for a positive and a negative sample.
    localparam logic [QBITS-1:0] QLIM_POS = 8'd127;
    localparam logic [QBITS-1:0] QLIM_NEG = 8'd128;

    // Command from the stream front end to the engine.
    typedef struct packed {
        logic       start;
        logic [1:0] kind;
        logic [1:0] mode;
    } fq_cmd_t;

    // Status from the engine back to the front end.
    typedef struct packed {
        logic idle;
        logic res_valid;
    } fq_stat_t;

    // Largest quantized magnitude for a mode; codes that mean nothing act as int2.
    function automatic logic [QBITS-1:0] qmax_of_mode(input logic [1:0] mode);
        logic [QBITS-1:0] qmax;
        case (mode)
            MODE_INT8: qmax = QMAX_INT8;
            MODE_INT4: qmax = QMAX_INT4;
            default:   qmax = QMAX_INT2;
        endcase
        return qmax;
    endfunction

endpackage

/* hdl/symmetric_fake_quantizer_top.sv */
// Top level of the symmetric per-tensor fake quantizer: stream ports and result register.
`timescale 1ns / 1ps

// The tensor is sent twice. A clear beat zeroes the running absolute maximum,
// calibrate beats fold |sample| into it, and each quantize beat returns
// q = round(sample*qmax/max), rounded half away from zero and clamped to
// [-128,127], together with round(q*max/qmax) saturated to the sample format;
// with a zero maximum both are 0. qmax is 127, 7 or 1 for the int8, int4 and
// int2 modes set on the configuration channel, which should only be written
// while the block is idle. A calibrate or quantize beat is finished before
// the next beat is taken. With a zero maximum a quantize beat goes straight
// to its result; otherwise one shared compare-and-subtract unit first finds
// q over 8 quotient steps plus an overflow check, then divides by 2*qmax
// over SAMPLE_WIDTH steps plus an overflow check, with a multiply step
// before and a clamp step after each division. A finished result sits in
// the output register, so the next beat is taken while it waits.
module symmetric_fake_quantizer_top #(
    parameter int  SAMPLE_WIDTH = fq_pkg::SAMPLE_WIDTH_DEF,
    localparam int IN_TW        = ((SAMPLE_WIDTH + 7) / 8) * 8,
    localparam int OUT_TW       = ((fq_pkg::QBITS + SAMPLE_WIDTH + 7) / 8) * 8
) (
    input  logic              aclk,
    input  logic              aresetn,

    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [IN_TW-1:0]  s_tdata,   // sample
    input  logic [1:0]        s_tuser,   // kind

    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [OUT_TW-1:0] m_tdata,   // quantized, dequantized

    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [1:0]        cfg_data   // quant_mode
);

    localparam int W  = SAMPLE_WIDTH;
    localparam int QB = fq_pkg::QBITS;

    logic [1:0]        mode_reg, mode_next;
    logic              m_tvalid_reg, m_tvalid_next;
    logic [OUT_TW-1:0] m_tdata_reg, m_tdata_next;

    fq_pkg::fq_cmd_t   cmd;
    fq_pkg::fq_stat_t  stat;
    logic              res_ready;
    logic [QB-1:0]     quantized;
    logic [W-1:0]      dequantized;

    // The mode register takes every write; writes must only be made while idle, which the block does not enforce.
    assign cfg_ready = 1'b1;
    assign mode_next = (cfg_valid && cfg_ready) ? cfg_data : mode_reg;

    // A beat is taken whenever the engine is idle, even if a result waits.
    assign s_tready  = stat.idle;
    assign cmd.start = s_tvalid && s_tready;
    assign cmd.kind  = s_tuser;
    assign cmd.mode  = mode_reg;

    // The output register frees itself in the same cycle as it is taken.
    assign res_ready = !m_tvalid_reg || m_tready;

    fq_engine #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_engine (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .sample      (s_tdata[W-1:0]),
        .res_ready   (res_ready),
        .stat        (stat),
        .quantized   (quantized),
        .dequantized (dequantized)
    );

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (stat.res_valid && res_ready) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = OUT_TW'({dequantized, quantized});
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg     <= fq_pkg::MODE_INT8;
            m_tvalid_reg <= 1'b0;
        end else begin
            mode_reg     <= mode_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

/* hdl/fq_subtract.sv */
// Shared compare-and-subtract unit of the quantizer engine.
`timescale 1ns / 1ps

module fq_subtract #(
    parameter int WIDTH = 41
) (
    input  logic [WIDTH-1:0] a,
    input  logic [WIDTH-1:0] b,
    output logic             ge,
    output logic [WIDTH-1:0] diff
);

    logic borrow;

    assign {borrow, diff} = {1'b0, a} - {1'b0, b};
    assign ge = ~borrow;

endmodule

/* hdl/fq_engine.sv */
// Sequencer and datapath of the quantizer: maximum tracking and both divisions.
`timescale 1ns / 1ps

module fq_engine #(
    parameter int SAMPLE_WIDTH = fq_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  fq_pkg::fq_cmd_t          cmd,
    input  logic [SAMPLE_WIDTH-1:0]  sample,
    input  logic                     res_ready,
    output fq_pkg::fq_stat_t         stat,
    output logic [fq_pkg::QBITS-1:0] quantized,
    output logic [SAMPLE_WIDTH-1:0]  dequantized
);

    localparam int W  = SAMPLE_WIDTH;
    localparam int QB = fq_pkg::QBITS;
    localparam int PW = W + QB;
    localparam int NW = W + QB + 1;
    localparam int CW = $clog2(W + 1);

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_CAL  = 6'b000010,
        ST_LOAD = 6'b000100,
        ST_DIV  = 6'b001000,
        ST_FIN  = 6'b010000,
        ST_DONE = 6'b100000
    } state_t;

    state_t          state_reg, state_next;
    logic [W-1:0]    max_reg, max_next;
    logic [W-1:0]    mag_reg, mag_next;
    logic            neg_reg, neg_next;
    logic            phase_reg, phase_next;
    logic            first_reg, first_next;
    logic            ovf_reg, ovf_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic [NW-1:0]   rem_reg, rem_next;
    logic [NW-1:0]   dsr_reg, dsr_next;
    logic [W-1:0]    quo_reg, quo_next;
    logic [QB-1:0]   qmag_reg, qmag_next;
    logic [QB-1:0]   q_res_reg, q_res_next;
    logic [W-1:0]    dq_res_reg, dq_res_next;

    logic [QB-1:0]   qmax;
    logic [QB-1:0]   limit;
    logic [W-1:0]    mul_a;
    logic [QB-1:0]   mul_b;
    logic [PW-1:0]   prod;
    logic [NW-1:0]   add_b;
    logic [NW-1:0]   load_val;
    logic [NW-1:0]   dsr_load;
    logic [NW-1:0]   sub_a;
    logic [NW-1:0]   sub_b;
    logic            sub_ge;
    logic [NW-1:0]   sub_diff;
    logic [QB-1:0]   qraw;
    logic [QB-1:0]   qsel;
    logic [W-1:0]    rlim;
    logic [W-1:0]    dqsel;
    logic            in_neg;

    assign qmax  = fq_pkg::qmax_of_mode(cmd.mode);
    assign limit = neg_reg ? fq_pkg::QLIM_NEG : fq_pkg::QLIM_POS;

    // One multiplier serves both loads: 2*|x|*qmax + M, then 2*|q|*M + qmax.
    assign mul_a    = phase_reg ? max_reg : mag_reg;
    assign mul_b    = phase_reg ? qmag_reg : qmax;
    assign prod     = PW'(mul_a) * PW'(mul_b);
    assign add_b    = phase_reg ? NW'(qmax) : NW'(max_reg);
    assign load_val = NW'({prod, 1'b0}) + add_b;

    // Divisor placed above the quotient field for the overflow check: 2M or 2*qmax.
    assign dsr_load = phase_reg ? (NW'({qmax[QB-2:0], 1'b0}) << W)
                                : (NW'(max_reg) << (QB + 1));

    assign sub_a = (state_reg == ST_CAL) ? NW'(mag_reg) : rem_reg;
    assign sub_b = (state_reg == ST_CAL) ? NW'(max_reg) : dsr_reg;

    fq_subtract #(
        .WIDTH (NW)
    ) u_sub (
        .a    (sub_a),
        .b    (sub_b),
        .ge   (sub_ge),
        .diff (sub_diff)
    );

    assign qraw  = quo_reg[QB-1:0];
    assign qsel  = (ovf_reg || (qraw > limit)) ? limit : qraw;
    assign rlim  = neg_reg ? (W'(1) << (W - 1)) : ((W'(1) << (W - 1)) - W'(1));
    assign dqsel = (ovf_reg || (quo_reg > rlim)) ? rlim : quo_reg;
    assign in_neg = sample[W-1];

    always_comb begin
        state_next  = state_reg;
        max_next    = max_reg;
        mag_next    = mag_reg;
        neg_next    = neg_reg;
        phase_next  = phase_reg;
        first_next  = first_reg;
        ovf_next    = ovf_reg;
        cnt_next    = cnt_reg;
        rem_next    = rem_reg;
        dsr_next    = dsr_reg;
        quo_next    = quo_reg;
        qmag_next   = qmag_reg;
        q_res_next  = q_res_reg;
        dq_res_next = dq_res_reg;

        case (state_reg)
            ST_IDLE: begin
                if (cmd.start) begin
                    neg_next   = in_neg;
                    mag_next   = in_neg ? (W'(0) - sample) : sample;
                    phase_next = 1'b0;
                    case (cmd.kind)
                        fq_pkg::KIND_CLEAR: begin
                            max_next = '0;
                        end
                        fq_pkg::KIND_CALIB: begin
                            state_next = ST_CAL;
                        end
                        fq_pkg::KIND_QUANTIZE: begin
                            if (max_reg == '0) begin
                                q_res_next  = '0;
                                dq_res_next = '0;
                                state_next  = ST_DONE;
                            end else begin
                                state_next = ST_LOAD;
                            end
                        end
                        default: begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_CAL: begin
                if (sub_ge) begin
                    max_next = mag_reg;
                end
                state_next = ST_IDLE;
            end
            ST_LOAD: begin
                rem_next   = load_val;
                dsr_next   = dsr_load;
                first_next = 1'b1;
                quo_next   = '0;
                cnt_next   = phase_reg ? CW'(W) : CW'(QB);
                state_next = ST_DIV;
            end
            ST_DIV: begin
                dsr_next = dsr_reg >> 1;
                if (first_reg) begin
                    // The quotient does not fit its field: saturate later.
                    ovf_next   = sub_ge;
                    first_next = 1'b0;
                end else begin
                    if (sub_ge) begin
                        rem_next = sub_diff;
                    end
                    quo_next = {quo_reg[W-2:0], sub_ge};
                    cnt_next = cnt_reg - CW'(1);
                    if (cnt_reg == CW'(1)) begin
                        state_next = ST_FIN;
                    end
                end
            end
            ST_FIN: begin
                if (!phase_reg) begin
                    qmag_next  = qsel;
                    phase_next = 1'b1;
                    state_next = ST_LOAD;
                end else begin
                    q_res_next  = neg_reg ? (QB'(0) - qmag_reg) : qmag_reg;
                    dq_res_next = neg_reg ? (W'(0) - dqsel) : dqsel;
                    state_next  = ST_DONE;
                end
            end
            ST_DONE: begin
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            max_reg   <= '0;
        end else begin
            state_reg <= state_next;
            max_reg   <= max_next;
        end
    end

    always_ff @(posedge aclk) begin
        mag_reg    <= mag_next;
        neg_reg    <= neg_next;
        phase_reg  <= phase_next;
        first_reg  <= first_next;
        ovf_reg    <= ovf_next;
        cnt_reg    <= cnt_next;
        rem_reg    <= rem_next;
        dsr_reg    <= dsr_next;
        quo_reg    <= quo_next;
        qmag_reg   <= qmag_next;
        q_res_reg  <= q_res_next;
        dq_res_reg <= dq_res_next;
    end

    assign stat.idle      = (state_reg == ST_IDLE);
    assign stat.res_valid = (state_reg == ST_DONE);
    assign quantized      = q_res_reg;
    assign dequantized    = dq_res_reg;

    // The first division never needs more than a quantized value's worth of steps.
    a_div1_steps: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV && !phase_reg) |-> (cnt_reg <= CW'(QB)))
        else $error("first division step count out of range");

    // Items are only taken while the sequencer is idle.
    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.start |-> (state_reg == ST_IDLE))
        else $error("item accepted while busy");

    // A non-negative sample never yields a negative result.
    a_sign: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE && !neg_reg) |-> (!dq_res_reg[W-1] && !q_res_reg[QB-1]))
        else $error("negative result for a non-negative sample");

    // The running maximum only moves on a clear or a calibrate item.
    a_max_update: assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(aresetn) && !$stable(max_reg)) |->
            (($past(state_reg) == ST_CAL) ||
             $past(cmd.start && (cmd.kind == fq_pkg::KIND_CLEAR))))
        else $error("running maximum changed outside clear or calibrate");

endmodule

/* verif/symmetric_fake_quantizer_top_test.sv */
// Self-checking testbench of the symmetric fake quantizer top level.
`timescale 1ns / 1ps

module symmetric_fake_quantizer_top_test;

    localparam int SW     = fq_pkg::SAMPLE_WIDTH_DEF;
    localparam int QBITS  = fq_pkg::QBITS;
    localparam int IN_TW  = ((SW + 7) / 8) * 8;
    localparam int OUT_TW = ((QBITS + SW + 7) / 8) * 8;

    // Codes that the package does not name: the int2 mode, the spare mode
    // and the spare kind, which the block has to ignore.
    localparam logic [1:0] MODE_INT2   = 2'd2;
    localparam logic [1:0] MODE_SPARE  = 2'd3;
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    localparam logic [SW-1:0] SAMPLE_MAX = {1'b0, {(SW-1){1'b1}}};
    localparam logic [SW-1:0] SAMPLE_MIN = {1'b1, {(SW-1){1'b0}}};

    // Quiet time after the last result; it also covers clear and calibrate
    // beats that leave no result behind them.
    localparam int QUIET_CYCLES = SW + 32;

    // Number of counted beats in the random part.
    localparam int RANDOM_ITEMS = 1250;

    typedef struct packed {
        logic [QBITS-1:0] quantized;
        logic [SW-1:0]    dequantized;
    } fq_result_t;

    logic              aclk      = 1'b0;
    logic              aresetn   = 1'b0;
    logic              s_tvalid  = 1'b0;
    logic              s_tready;
    logic [IN_TW-1:0]  s_tdata   = '0;
    logic [1:0]        s_tuser   = fq_pkg::KIND_CLEAR;
    logic              m_tvalid;
    logic              m_tready  = 1'b0;
    logic [OUT_TW-1:0] m_tdata;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [1:0]        cfg_data  = fq_pkg::MODE_INT8;

    // Shadow of the block's state and register, updated beat by beat.
    logic [63:0] peak_magnitude    = '0;
    logic [1:0]  quant_mode_shadow = fq_pkg::MODE_INT8;

    // Quantize results that have been predicted but not yet seen.
    fq_result_t pending_quantized[$];

    int  error_count      = 0;
    bit  sender_no_idle   = 1'b0;
    bit  receiver_no_idle = 1'b0;

    symmetric_fake_quantizer_top #(
        .SAMPLE_WIDTH(SW)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    always #10 aclk = ~aclk;

    // Magnitude of a two's complement sample. The most negative sample keeps
    // its magnitude of 2^(SW-1), which still fits the unsigned result.
    function automatic logic [63:0] magnitude_of(input logic [SW-1:0] sample);
        logic [SW-1:0] mag;
        mag = sample[SW-1] ? (~sample + 1'b1) : sample;
        return {{(64-SW){1'b0}}, mag};
    endfunction

    // Quantizes one sample against the current running maximum and scales the
    // quantized value back. Both roundings are half away from zero, which for
    // magnitudes is floor((2*n + d) / (2*d)).
    function automatic fq_result_t quantize_sample(input logic [SW-1:0] sample);
        fq_result_t  res;
        logic        neg;
        logic [63:0] mag;
        logic [63:0] qmax;
        logic [63:0] limit;
        logic [63:0] qmag;
        logic [63:0] recon;
        logic [63:0] recon_limit;
        res = '0;
        if (peak_magnitude == 0) begin
            return res;
        end
        neg = sample[SW-1];
        mag = magnitude_of(sample);
        case (quant_mode_shadow)
            fq_pkg::MODE_INT8: qmax = 64'd127;
            fq_pkg::MODE_INT4: qmax = 64'd7;
            default:           qmax = 64'd1;
        endcase
        limit = neg ? 64'd128 : 64'd127;
        qmag  = (2 * mag * qmax + peak_magnitude) / (2 * peak_magnitude);
        if (qmag > limit) begin
            qmag = limit;
        end
        recon       = (2 * qmag * peak_magnitude + qmax) / (2 * qmax);
        recon_limit = neg ? (64'd1 << (SW - 1)) : ((64'd1 << (SW - 1)) - 1);
        if (recon > recon_limit) begin
            recon = recon_limit;
        end
        res.quantized   = neg ? -qmag[QBITS-1:0] : qmag[QBITS-1:0];
        res.dequantized = neg ? -recon[SW-1:0] : recon[SW-1:0];
        return res;
    endfunction

    // Sends one beat after a random gap and folds it into the shadow state at
    // the edge where it is taken. The valid is only lowered when a gap follows,
    // so back-to-back beats never see it dropped and raised in one step.
    task automatic send_item(input logic [1:0] kind, input logic [SW-1:0] sample);
        int gap;
        gap = sender_no_idle ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= IN_TW'(sample);
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        case (kind)
            fq_pkg::KIND_CLEAR: begin
                peak_magnitude = '0;
            end
            fq_pkg::KIND_CALIB: begin
                if (magnitude_of(sample) > peak_magnitude) begin
                    peak_magnitude = magnitude_of(sample);
                end
            end
            fq_pkg::KIND_QUANTIZE: begin
                pending_quantized.push_back(quantize_sample(sample));
            end
            default: begin
            end
        endcase
    endtask

    // Stops sending, waits for every outstanding result and then lets the
    // engine run out any clear or calibrate beat still in flight.
    task automatic wait_until_idle();
        s_tvalid <= 1'b0;
        while (pending_quantized.size() != 0) @(posedge aclk);
        repeat (QUIET_CYCLES) @(posedge aclk);
    endtask

    // Writes the mode register; only called while the block is idle.
    task automatic write_mode(input logic [1:0] mode);
        cfg_valid <= 1'b1;
        cfg_data  <= mode;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid         <= 1'b0;
        quant_mode_shadow  = mode;
    endtask

    // Random sample whose magnitude spans every scale, with the extremes
    // thrown in now and then.
    function automatic logic [SW-1:0] random_sample();
        logic [SW-1:0] value;
        case ($urandom_range(0, 19))
            0:       value = SAMPLE_MIN;
            1:       value = SAMPLE_MAX;
            2:       value = '0;
            3:       value = '1;
            default: begin
                value = SW'($urandom) >> $urandom_range(0, SW - 1);
                if ($urandom_range(0, 1) == 1) begin
                    value = -value;
                end
            end
        endcase
        return value;
    endfunction

    // With the maximum at zero straight after reset, every quantize beat
    // must give zeros, and the spare kind must leave no trace.
    task automatic test_zero_maximum();
        send_item(fq_pkg::KIND_QUANTIZE, SW'(12345));
        send_item(fq_pkg::KIND_QUANTIZE, '1);
        send_item(KIND_UNUSED, SW'(777));
        send_item(fq_pkg::KIND_QUANTIZE, SAMPLE_MIN);
    endtask

    // int8 rounding: exact scale, the half-way case, small values, and
    // samples well beyond the maximum in both directions.
    task automatic test_int8_rounding();
        wait_until_idle();
        write_mode(fq_pkg::MODE_INT8);
        send_item(fq_pkg::KIND_CLEAR, '0);
        send_item(fq_pkg::KIND_CALIB, SW'(1000));
        send_item(fq_pkg::KIND_CALIB, -SW'(400));
        send_item(fq_pkg::KIND_QUANTIZE, SW'(1000));
        send_item(fq_pkg::KIND_QUANTIZE, -SW'(1000));
        send_item(fq_pkg::KIND_QUANTIZE, SW'(500));
        send_item(fq_pkg::KIND_QUANTIZE, -SW'(500));
        send_item(fq_pkg::KIND_QUANTIZE, SW'(7));
        send_item(fq_pkg::KIND_QUANTIZE, '0);
        send_item(fq_pkg::KIND_QUANTIZE, SAMPLE_MAX);
        send_item(fq_pkg::KIND_QUANTIZE, SAMPLE_MIN);
    endtask

    // Dequantized saturation: positive with the maximum at 2^(SW-1), negative
    // in int2 mode where q is clamped to -128 and 128*max no longer fits.
    task automatic test_saturation();
        send_item(fq_pkg::KIND_CLEAR, '0);
        send_item(fq_pkg::KIND_CALIB, SAMPLE_MIN);
        send_item(fq_pkg::KIND_QUANTIZE, SAMPLE_MAX);
        send_item(fq_pkg::KIND_QUANTIZE, SAMPLE_MIN);
        wait_until_idle();
        write_mode(MODE_INT2);
        send_item(fq_pkg::KIND_CLEAR, '0);
        send_item(fq_pkg::KIND_CALIB, SW'(16843009));
        send_item(fq_pkg::KIND_QUANTIZE, SAMPLE_MIN);
        send_item(fq_pkg::KIND_QUANTIZE, SAMPLE_MAX);
    endtask

    // int4 against a tiny maximum, then the spare mode, which behaves as int2,
    // and finally a clear that takes the maximum back to zero.
    task automatic test_int4_and_spare_mode();
        wait_until_idle();
        write_mode(fq_pkg::MODE_INT4);
        send_item(fq_pkg::KIND_CLEAR, '0);
        send_item(fq_pkg::KIND_CALIB, SW'(3));
        send_item(fq_pkg::KIND_QUANTIZE, SAMPLE_MAX);
        send_item(fq_pkg::KIND_QUANTIZE, -SW'(2));
        send_item(KIND_UNUSED, SAMPLE_MAX);
        wait_until_idle();
        write_mode(MODE_SPARE);
        send_item(fq_pkg::KIND_QUANTIZE, SW'(2));
        send_item(fq_pkg::KIND_QUANTIZE, '1);
        send_item(fq_pkg::KIND_CLEAR, '0);
        send_item(fq_pkg::KIND_QUANTIZE, SW'(9));
    endtask

    // Random tensors. Most are sent the proper way, clear then calibrate then
    // quantize over the same elements; the rest quantize against a stale
    // maximum, calibrate only part of the tensor, or are plain noise with
    // every kind mixed in. The mode changes every hundred or so beats.
    task automatic test_random_tensors();
        logic [SW-1:0] tensor [8];
        logic [1:0]    kind;
        int            counted;
        int            since_mode;
        int            phase;
        int            size;
        int            style;
        int            cut;
        counted    = 0;
        since_mode = 0;
        phase      = 0;
        while (counted < RANDOM_ITEMS) begin
            if (since_mode >= 100) begin
                wait_until_idle();
                // The first four phases walk through every mode code.
                write_mode(phase < 4 ? 2'(phase) : 2'($urandom_range(0, 3)));
                phase      = phase + 1;
                since_mode = 0;
            end
            sender_no_idle   = ($urandom_range(0, 3) == 0);
            receiver_no_idle = ($urandom_range(0, 3) == 0);
            size  = $urandom_range(1, 8);
            style = $urandom_range(0, 9);
            for (int i = 0; i < size; i++) begin
                tensor[i] = random_sample();
            end
            if (style <= 6 || style == 9) begin
                send_item(fq_pkg::KIND_CLEAR, random_sample());
                cut = (style == 9) ? $urandom_range(0, size - 1) : size;
                for (int i = 0; i < cut; i++) begin
                    send_item(fq_pkg::KIND_CALIB, tensor[i]);
                end
                counted = counted + 1 + cut;
            end
            if (style != 8) begin
                for (int i = 0; i < size; i++) begin
                    send_item(fq_pkg::KIND_QUANTIZE, tensor[i]);
                end
                counted = counted + size;
            end else begin
                for (int i = 0; i < size; i++) begin
                    kind = 2'($urandom_range(0, 3));
                    send_item(kind, tensor[i]);
                    if (kind != KIND_UNUSED) begin
                        counted = counted + 1;
                    end
                end
            end
            since_mode = since_mode + size;
        end
    endtask

    // Receiver: stalls a random number of cycles before each beat, then
    // compares the beat with the oldest prediction field by field. The ready
    // stays high across beats when no stall follows.
    initial begin : result_checker
        int         stall;
        fq_result_t expected;
        fq_result_t actual;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            stall = receiver_no_idle ? 0 : $urandom_range(0, 19);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
            actual.quantized   = m_tdata[QBITS-1:0];
            actual.dequantized = m_tdata[QBITS+SW-1:QBITS];
            if (pending_quantized.size() == 0) begin
                $error("result beat with no prediction waiting: quantized %0d, dequantized %0d",
                       $signed(actual.quantized), $signed(actual.dequantized));
                error_count = error_count + 1;
            end else begin
                expected = pending_quantized.pop_front();
                if (actual.quantized !== expected.quantized) begin
                    $error("quantized: expected %0d, actual %0d",
                           $signed(expected.quantized), $signed(actual.quantized));
                    error_count = error_count + 1;
                end
                if (actual.dequantized !== expected.dequantized) begin
                    $error("dequantized: expected %0d, actual %0d",
                           $signed(expected.dequantized), $signed(actual.dequantized));
                    error_count = error_count + 1;
                end
            end
        end
    end

    // Main sequence: reset once, the directed tests, the random tensors, then
    // drain and report.
    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        test_zero_maximum();
        test_int8_rounding();
        test_saturation();
        test_int4_and_spare_mode();
        test_random_tensors();
        wait_until_idle();
        if (error_count == 0 && pending_quantized.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // Watchdog: 20 ms is several times the slowest correct run, in which every
    // beat waits out the longest gap, the full quantize time and the longest
    // stall on the result side.
    initial begin
        #20_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
